// ----- design/pbt_pkg.sv -----
// Shared types, constants and helper functions of the piece block tracker.
`default_nettype none

package pbt_pkg;

   localparam int MAX_PIECES  = 1024;
   localparam int MAX_BLOCKS  = 64;
   localparam int BLOCK_BYTES = 16384;

   localparam int PIECE_W     = $clog2(MAX_PIECES);
   localparam int PCOUNT_W    = 11;
   localparam int BYTES_W     = 21;
   localparam int OFFSET_W    = 20;
   localparam int LENGTH_W    = 15;
   localparam int TOTAL_W     = 17;
   localparam int TALLY_W     = 7;
   localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);
   localparam int BIDX_W      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int NBLK_W      = $clog2(MAX_BLOCKS + 1);
   localparam int PROD_W      = PCOUNT_W + NBLK_W;

   localparam logic [1:0] CSR_PIECE_COUNT      = 2'd0;
   localparam logic [1:0] CSR_PIECE_BYTES      = 2'd1;
   localparam logic [1:0] CSR_LAST_PIECE_BYTES = 2'd2;

   localparam logic [2:0] KIND_ADD      = 3'd0;
   localparam logic [2:0] KIND_COMPLETE = 3'd1;
   localparam logic [2:0] KIND_VERIFY   = 3'd2;
   localparam logic [2:0] KIND_MISSING  = 3'd3;
   localparam logic [2:0] KIND_PROGRESS = 3'd4;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic [MAX_BLOCKS-1:0] block_map;
      logic [TALLY_W-1:0]    block_tally;
      logic                  verified_mark;
   } entry_type;

   typedef struct packed {
      logic [2:0]          kind;
      logic [PIECE_W-1:0]  piece;
      logic [OFFSET_W-1:0] offset;
   } op_type;

   typedef struct packed {
      logic [PCOUNT_W-1:0] piece_count;
      logic [BYTES_W-1:0]  piece_bytes;
      logic [BYTES_W-1:0]  last_piece_bytes;
   } cfg_type;

   typedef struct packed {
      logic      we;
      entry_type entry;
      logic      bump;
   } writeback_type;

   typedef struct packed {
      logic                ok;
      logic [OFFSET_W-1:0] block_offset;
      logic [LENGTH_W-1:0] block_length;
      logic [TOTAL_W-1:0]  received_total;
      logic [TOTAL_W-1:0]  download_blocks;
   } result_type;

   // Blocks in a piece of the given size, rounded up and saturated.
   function automatic logic [NBLK_W-1:0] blocks_of_bytes(input logic [BYTES_W-1:0] bytes);
      logic [BYTES_W:0]           sum;
      logic [BYTES_W-BLOCK_SHIFT:0] n;
      sum = {1'b0, bytes} + (BYTES_W+1)'(BLOCK_BYTES - 1);
      n   = sum[BYTES_W:BLOCK_SHIFT];
      if (n > (BYTES_W-BLOCK_SHIFT+1)'(MAX_BLOCKS)) begin
         return NBLK_W'(MAX_BLOCKS);
      end
      return NBLK_W'(n);
   endfunction

   function automatic logic [PCOUNT_W-1:0] pieces_in_use(input logic [PCOUNT_W-1:0] count);
      if (count > PCOUNT_W'(MAX_PIECES)) begin
         return PCOUNT_W'(MAX_PIECES);
      end
      return count;
   endfunction

endpackage

`default_nettype wire

// ----- design/piece_block_tracker_unit.sv -----
// Top level: sequencer, configuration registers, running total and result registers.
// An accepted item has its operation and piece entry registered, runs in ST_EXEC, and gives a registered result strobe.
// A new item is taken only once ST_EXEC has ended, for the read then write-back of the piece memory.
// Reset: a clearing pass zeroes the 1024 piece entries, one a cycle; busy holds until the pass
// ends, while configuration writes are still taken.
// Results are shown for one cycle on rsp_valid; the receiver cannot stall.
`default_nettype none

module piece_block_tracker_unit (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           start,
   output logic                          busy,
   input  wire  [2:0]                    req_kind,
   input  wire  [pbt_pkg::PIECE_W-1:0]   req_piece,
   input  wire  [pbt_pkg::OFFSET_W-1:0]  req_offset,
   output logic                          rsp_valid,
   output logic                          rsp_ok,
   output logic [pbt_pkg::OFFSET_W-1:0]  rsp_block_offset,
   output logic [pbt_pkg::LENGTH_W-1:0]  rsp_block_length,
   output logic [pbt_pkg::TOTAL_W-1:0]   rsp_received_total,
   output logic [pbt_pkg::TOTAL_W-1:0]   rsp_download_blocks,
   input  wire                           csr_we,
   input  wire  [1:0]                    csr_index,
   input  wire  [pbt_pkg::BYTES_W-1:0]   csr_wdata
);
   import pbt_pkg::*;

   state_type           state_ff, state_in;
   logic [PIECE_W-1:0]  clear_idx_ff, clear_idx_in;
   op_type              op_ff, op_in;
   cfg_type             cfg_ff, cfg_in;
   logic [TOTAL_W-1:0]  grand_ff, grand_in;
   logic                rsp_valid_ff, rsp_valid_in;
   result_type          result_ff, result_in;

   logic                accept;
   logic                mem_we;
   logic [PIECE_W-1:0]  mem_waddr;
   entry_type           mem_wdata;
   entry_type           rd_entry;
   writeback_type       wb;
   result_type          exec_result;

   assign accept = start && !busy;

   pbt_store u_store (
      .clock      (clock),
      .rd_en      (accept),
      .rd_addr    (req_piece),
      .wr_en      (mem_we),
      .wr_addr    (mem_waddr),
      .wr_data    (mem_wdata),
      .rd_data_ff (rd_entry)
   );

   pbt_exec u_exec (
      .op          (op_ff),
      .entry       (rd_entry),
      .cfg         (cfg_ff),
      .grand_tally (grand_ff),
      .wb          (wb),
      .result      (exec_result)
   );

   // Next state
   always_comb begin
      state_in     = state_ff;
      clear_idx_in = clear_idx_ff;
      case (state_ff)
         ST_CLEAR: begin
            clear_idx_in = clear_idx_ff + PIECE_W'(1);
            if (clear_idx_ff == PIECE_W'(MAX_PIECES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Outputs of the sequencer
   always_comb begin
      busy         = 1'b1;
      mem_we       = 1'b0;
      mem_waddr    = op_ff.piece;
      mem_wdata    = wb.entry;
      rsp_valid_in = 1'b0;
      result_in    = result_ff;
      grand_in     = grand_ff;
      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clear_idx_ff;
            mem_wdata = '0;
         end
         ST_IDLE: begin
            busy = 1'b0;
         end
         ST_EXEC: begin
            mem_we       = wb.we;
            rsp_valid_in = 1'b1;
            result_in    = exec_result;
            if (wb.bump) begin
               grand_in = grand_ff + TOTAL_W'(1);
            end
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   always_comb begin
      op_in = op_ff;
      if (accept) begin
         op_in.kind   = req_kind;
         op_in.piece  = req_piece;
         op_in.offset = req_offset;
      end
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_PIECE_COUNT:      cfg_in.piece_count      = PCOUNT_W'(csr_wdata);
            CSR_PIECE_BYTES:      cfg_in.piece_bytes      = csr_wdata;
            CSR_LAST_PIECE_BYTES: cfg_in.last_piece_bytes = csr_wdata;
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff                <= ST_CLEAR;
         clear_idx_ff            <= '0;
         grand_ff                <= '0;
         rsp_valid_ff            <= 1'b0;
         cfg_ff.piece_count      <= '0;
         cfg_ff.piece_bytes      <= BYTES_W'(262144);
         cfg_ff.last_piece_bytes <= BYTES_W'(262144);
      end else begin
         state_ff     <= state_in;
         clear_idx_ff <= clear_idx_in;
         grand_ff     <= grand_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      result_ff <= result_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_ok              = result_ff.ok;
   assign rsp_block_offset    = result_ff.block_offset;
   assign rsp_block_length    = result_ff.block_length;
   assign rsp_received_total  = result_ff.received_total;
   assign rsp_download_blocks = result_ff.download_blocks;

   a_rsp_follows_exec: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_EXEC))
      else $error("result strobe without an executed item");

   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> busy)
      else $error("item could be accepted during the clearing pass");

   a_write_owner: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_EXEC || state_ff == ST_CLEAR))
      else $error("memory written outside execute or clear");

   a_tally_step: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (grand_ff == $past(grand_ff) || grand_ff == $past(grand_ff) + TOTAL_W'(1)))
      else $error("running total moved by more than one block");

   a_exec_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC) |=> (state_ff == ST_IDLE && rsp_valid))
      else $error("execute did not finish with a result");

endmodule

`default_nettype wire

// ----- design/pbt_store.sv -----
// Piece entry memory: one write port, one read port with registered data.
`default_nettype none

module pbt_store (
   input  wire                         clock,
   input  wire                         rd_en,
   input  wire  [pbt_pkg::PIECE_W-1:0] rd_addr,
   input  wire                         wr_en,
   input  wire  [pbt_pkg::PIECE_W-1:0] wr_addr,
   input  wire  pbt_pkg::entry_type    wr_data,
   output pbt_pkg::entry_type          rd_data_ff
);
   import pbt_pkg::*;

   entry_type mem [0:MAX_PIECES-1];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- design/pbt_exec.sv -----
// Operation logic: turns one read piece entry into a result and a write-back.
`default_nettype none

module pbt_exec (
   input  wire  pbt_pkg::op_type           op,
   input  wire  pbt_pkg::entry_type        entry,
   input  wire  pbt_pkg::cfg_type          cfg,
   input  wire  [pbt_pkg::TOTAL_W-1:0]     grand_tally,
   output pbt_pkg::writeback_type          wb,
   output pbt_pkg::result_type             result
);
   import pbt_pkg::*;

   logic [PCOUNT_W-1:0]   piu;
   logic                  valid;
   logic                  is_last;
   logic [BYTES_W-1:0]    size;
   logic [NBLK_W-1:0]     nblk;
   logic                  full;

   logic [BIDX_W-1:0]     add_idx;
   logic                  add_in_range;
   logic                  add_marked;

   logic [MAX_BLOCKS-1:0] avail;
   logic [MAX_BLOCKS-1:0] lowest;
   logic [BIDX_W-1:0]     miss_idx;
   logic                  found;
   logic [BYTES_W-1:0]    miss_start;
   logic [BYTES_W-1:0]    rest;
   logic [LENGTH_W-1:0]   miss_len;

   logic [PROD_W-1:0]     product;
   logic [TOTAL_W-1:0]    total_sat;

   always_comb begin
      piu     = pieces_in_use(cfg.piece_count);
      valid   = {1'b0, op.piece} < piu;
      is_last = ({1'b0, op.piece} + PCOUNT_W'(1)) == piu;
      if (!valid) begin
         size = '0;
      end else if (is_last) begin
         size = cfg.last_piece_bytes;
      end else begin
         size = cfg.piece_bytes;
      end
      nblk = blocks_of_bytes(size);
      full = NBLK_W'(entry.block_tally) >= nblk;
   end

   // Block index of an arriving block.
   always_comb begin
      add_idx      = BIDX_W'(op.offset >> BLOCK_SHIFT);
      add_in_range = ((op.offset >> BLOCK_SHIFT) < OFFSET_W'(nblk));
      add_marked   = entry.block_map[add_idx];
   end

   // First absent block: isolate the lowest candidate bit, then encode it.
   always_comb begin
      for (int i = 0; i < MAX_BLOCKS; i++) begin
         avail[i] = (NBLK_W'(i) < nblk) && !entry.block_map[i];
      end
      lowest   = avail & (~avail + MAX_BLOCKS'(1));
      found    = |avail;
      miss_idx = '0;
      for (int i = 0; i < MAX_BLOCKS; i++) begin
         if (lowest[i]) begin
            miss_idx = miss_idx | BIDX_W'(i);
         end
      end
      miss_start = BYTES_W'(miss_idx) << BLOCK_SHIFT;
      rest       = size - miss_start;
      if (rest < BYTES_W'(BLOCK_BYTES)) begin
         miss_len = LENGTH_W'(rest);
      end else begin
         miss_len = LENGTH_W'(BLOCK_BYTES);
      end
   end

   always_comb begin
      product = PROD_W'(piu) * PROD_W'(blocks_of_bytes(cfg.piece_bytes));
      if (product > PROD_W'({TOTAL_W{1'b1}})) begin
         total_sat = '1;
      end else begin
         total_sat = TOTAL_W'(product);
      end
   end

   always_comb begin
      wb     = '0;
      result = '0;
      wb.entry = entry;
      case (op.kind)
         KIND_ADD: begin
            if (valid) begin
               if (entry.verified_mark) begin
                  result.ok = 1'b1;
               end else if (add_in_range) begin
                  result.ok = 1'b1;
                  if (!add_marked) begin
                     wb.we                      = 1'b1;
                     wb.bump                    = 1'b1;
                     wb.entry.block_map[add_idx] = 1'b1;
                     wb.entry.block_tally       = entry.block_tally + TALLY_W'(1);
                  end
               end
            end
         end
         KIND_COMPLETE: begin
            result.ok = valid && full;
         end
         KIND_VERIFY: begin
            if (valid) begin
               if (entry.verified_mark) begin
                  result.ok = 1'b1;
               end else if (full) begin
                  result.ok              = 1'b1;
                  wb.we                  = 1'b1;
                  wb.entry.verified_mark = 1'b1;
               end
            end
         end
         KIND_MISSING: begin
            if (valid && found) begin
               result.ok           = 1'b1;
               result.block_offset = OFFSET_W'(miss_start);
               result.block_length = miss_len;
            end
         end
         KIND_PROGRESS: begin
            result.ok              = 1'b1;
            result.received_total  = grand_tally;
            result.download_blocks = total_sat;
         end
         default: begin
            result = '0;
         end
      endcase
   end

endmodule

`default_nettype wire
